>>> rtl/core/lfp_pkg.sv
// Shared types and constants for the lidar frame parser.
// No dependencies; imported by every module of the block.
`default_nettype none

package lfp_pkg;

   localparam int FRAME_LENGTH = 9;
   // bytes 0..7 live in the cell chain, byte 8 (checksum) is compared on arrival
   localparam int CHAIN_LEN    = FRAME_LENGTH - 1;
   localparam int POS_W        = 4;
   localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_LENGTH - 1);

   localparam logic [7:0] HEADER_RESET = 8'h59;

   // register index decoded from paddr[2]
   localparam logic CSR_HEADER_IDX = 1'b0;

   // frame byte k sits in cell CHAIN_LEN-1-k when the checksum byte arrives
   localparam int CELL_HDR0   = CHAIN_LEN - 1;
   localparam int CELL_HDR1   = CHAIN_LEN - 2;
   localparam int CELL_DIST_L = CHAIN_LEN - 3;
   localparam int CELL_DIST_H = CHAIN_LEN - 4;
   localparam int CELL_STR_L  = CHAIN_LEN - 5;
   localparam int CELL_STR_H  = CHAIN_LEN - 6;

   typedef logic [7:0] byte_type;
   typedef byte_type [CHAIN_LEN-1:0] chain_type;

   typedef enum logic {
      ST_IDLE,
      ST_COLLECT
   } lfp_state_type;

   typedef struct packed {
      logic start;   // header byte taken while idle
      logic shift;   // byte enters the cell chain
      logic last;    // checksum byte taken, frame ends
   } lfp_ctrl_type;

endpackage

`default_nettype wire

>>> rtl/core/lfp_cell.sv
// One byte cell of the frame chain: takes its neighbor's byte on shift.
// Depends on lfp_pkg.
`default_nettype none

module lfp_cell
   import lfp_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     shift,
   input  wire byte_type d_in,
   output byte_type      q
);

   byte_type data_ff;
   byte_type data_in;

   always_comb begin
      data_in = shift ? d_in : data_ff;
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign q = data_ff;

endmodule

`default_nettype wire

>>> rtl/core/lfp_check.sv
// Running checksum, end-of-frame validation and held distance/strength.
// Depends on lfp_pkg; fed by the lfp_cell chain.
`default_nettype none

module lfp_check
   import lfp_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire lfp_ctrl_type ctrl,
   input  wire byte_type     rx_byte,
   input  wire byte_type     header,
   input  wire chain_type    cells,
   output logic [15:0]       distance,
   output logic [15:0]       strength,
   output logic              frame_ok
);

   byte_type    sum_ff, sum_in;
   logic [15:0] dist_ff, dist_in;
   logic [15:0] str_ff, str_in;
   logic        ok_ff, ok_in;
   logic        ok;

   assign ok = (cells[CELL_HDR0] == header) && (cells[CELL_HDR1] == header)
               && (rx_byte == sum_ff);

   always_comb begin
      sum_in  = sum_ff;
      dist_in = dist_ff;
      str_in  = str_ff;
      ok_in   = ok_ff;
      if (ctrl.start) begin
         sum_in = rx_byte;
      end else if (ctrl.shift) begin
         sum_in = sum_ff + rx_byte;
      end
      if (ctrl.last) begin
         ok_in = ok;
         if (ok) begin
            dist_in = {cells[CELL_DIST_H], cells[CELL_DIST_L]};
            str_in  = {cells[CELL_STR_H], cells[CELL_STR_L]};
         end
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
      ok_ff  <= ok_in;
      if (reset) begin
         dist_ff <= '0;
         str_ff  <= '0;
      end else begin
         dist_ff <= dist_in;
         str_ff  <= str_in;
      end
   end

   assign distance = dist_ff;
   assign strength = str_ff;
   assign frame_ok = ok_ff;

endmodule

`default_nettype wire

>>> rtl/core/lidar_frame_parser.sv
// Top level of the lidar serial frame parser: control, CSR port, cell chain.
// Depends on lfp_pkg, lfp_cell, lfp_check.
//
//   port group   | direction | payload
//   req_         | in        | rx_byte[7:0]
//   rsp_         | out       | distance[15:0], strength[15:0], frame_ok
//   APB (p*)     | in/out    | header_value at byte address 0
//
// One byte is taken per cycle while req_ready is high; the result is registered
// with the ninth byte. The chain shifts one cell per frame byte but the checksum.
// Synchronous active-high reset; header_value returns to 0x59, held values to 0.
// req_ready drops only while the checksum byte is due and the previous result
// is still waiting on rsp_ready.
`default_nettype none

module lidar_frame_parser
   import lfp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_rx_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [15:0]      rsp_distance,
   output logic [15:0]      rsp_strength,
   output logic             rsp_frame_ok,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   lfp_state_type    state_ff, state_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   byte_type         header_ff, header_in;
   logic             rsp_valid_ff, rsp_valid_in;
   lfp_ctrl_type     ctrl;
   chain_type        cells;
   logic             accept;
   logic             is_header;
   logic             at_last;

   // ---------------- CSR port ----------------
   assign pready = 1'b1;

   always_comb begin
      header_in = header_ff;
      if (psel && penable && pwrite && (paddr[2] == CSR_HEADER_IDX)) begin
         header_in = pwdata[7:0];
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[2] == CSR_HEADER_IDX) begin
         prdata = {24'd0, header_ff};
      end
   end

   // ---------------- control ----------------
   assign at_last   = (state_ff == ST_COLLECT) && (pos_ff == LAST_POS);
   assign req_ready = !(at_last && rsp_valid_ff && !rsp_ready);
   assign accept    = req_valid && req_ready;
   assign is_header = (req_rx_byte == header_ff);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && is_header) begin
               state_in = ST_COLLECT;
            end
         end
         ST_COLLECT: begin
            if (accept && at_last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctrl = '0;
      unique case (state_ff)
         ST_IDLE: begin
            ctrl.start = accept && is_header;
            ctrl.shift = accept && is_header;
         end
         ST_COLLECT: begin
            ctrl.shift = accept && !at_last;
            ctrl.last  = accept && at_last;
         end
         default: ctrl = '0;
      endcase
   end

   always_comb begin
      pos_in = pos_ff;
      if (ctrl.start) begin
         pos_in = POS_W'(1);
      end else if (ctrl.last) begin
         pos_in = '0;
      end else if (ctrl.shift) begin
         pos_in = pos_ff + POS_W'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctrl.last) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= '0;
         header_ff    <= HEADER_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         header_ff    <= header_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // ---------------- byte chain ----------------
   for (genvar i = 0; i < CHAIN_LEN; i++) begin : g_cell
      if (i == 0) begin : g_head
         lfp_cell u_cell (
            .clock (clock),
            .shift (ctrl.shift),
            .d_in  (req_rx_byte),
            .q     (cells[i])
         );
      end else begin : g_body
         lfp_cell u_cell (
            .clock (clock),
            .shift (ctrl.shift),
            .d_in  (cells[i-1]),
            .q     (cells[i])
         );
      end
   end

   lfp_check u_check (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (ctrl),
      .rx_byte  (req_rx_byte),
      .header   (header_ff),
      .cells    (cells),
      .distance (rsp_distance),
      .strength (rsp_strength),
      .frame_ok (rsp_frame_ok)
   );

   // ---------------- assertions ----------------
   a_idle_pos_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (pos_ff == '0))
      else $error("byte position nonzero while idle");

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      (pos_ff <= LAST_POS))
      else $error("byte position past frame end");

   a_last_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      ctrl.last |=> rsp_valid_ff)
      else $error("frame end without result");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      ctrl.last |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwritten before taken");

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
// Self-checking testbench for lidar_frame_parser: directed frames, random traffic, back-pressure.
// Depends on lfp_pkg and the lidar_frame_parser RTL; the frame parser is predicted in-line.
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import lfp_pkg::FRAME_LENGTH;
   import lfp_pkg::HEADER_RESET;

   localparam logic [2:0] HEADER_ADDR  = 3'd0;
   localparam int         DRAIN_CYCLES = 8;
   localparam int         CYCLE_LIMIT  = 200000;
   localparam int         HOLD_CYCLES  = 300;

   typedef logic [7:0] frame_image_type [0:FRAME_LENGTH-1];

   typedef struct packed {
      logic [15:0] distance;
      logic [15:0] strength;
      logic        frame_ok;
   } reading_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [15:0] rsp_distance;
   logic [15:0] rsp_strength;
   logic        rsp_frame_ok;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = 3'd0;
   logic [31:0] pwdata = 32'd0;
   logic [31:0] prdata;
   logic        pready;

   lidar_frame_parser dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_rx_byte  (req_rx_byte),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_distance (rsp_distance),
      .rsp_strength (rsp_strength),
      .rsp_frame_ok (rsp_frame_ok),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .pready       (pready)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // parser copy: header register, frame state, held readings
   logic [7:0]  hdr_reg = HEADER_RESET;
   logic        in_frm = 1'b0;
   logic [3:0]  frm_pos = 4'd0;
   logic [7:0]  frm_buf [0:FRAME_LENGTH-1];
   logic [15:0] held_dist = 16'd0;
   logic [15:0] held_str = 16'd0;
   reading_type pending_readings[$];

   int mismatches = 0;
   int cycle_count = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_left = 0;

   function automatic void parse_rx_byte(input logic [7:0] b);
      logic [7:0] sum;
      logic       ok;
      if (!in_frm) begin
         if (b == hdr_reg) begin
            frm_buf[0] = b;
            in_frm = 1'b1;
            frm_pos = 4'd1;
         end
      end else begin
         frm_buf[frm_pos] = b;
         frm_pos = frm_pos + 4'd1;
         if (frm_pos == FRAME_LENGTH) begin
            in_frm = 1'b0;
            frm_pos = 4'd0;
            sum = 8'd0;
            for (int k = 0; k < FRAME_LENGTH - 1; k++) sum += frm_buf[k];
            // headers are compared against the register as it is now
            ok = (frm_buf[0] == hdr_reg) && (frm_buf[1] == hdr_reg)
                 && (frm_buf[FRAME_LENGTH-1] == sum);
            if (ok) begin
               held_dist = {frm_buf[3], frm_buf[2]};
               held_str  = {frm_buf[5], frm_buf[4]};
            end
            pending_readings.push_back('{held_dist, held_str, ok});
         end
      end
   endfunction

   function automatic void check_field(input string name, input logic [15:0] want,
                                       input logic [15:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= 10)
            $display("%0t mismatch on %s: expected %h, got %h", $time, name, want, got);
      end
   endfunction

   always @(posedge clock) begin
      reading_type want;
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("lidar_frame_parser regression: fail");
         $finish;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_readings.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t result item with no frame pending: %h %h %b", $time,
                        rsp_distance, rsp_strength, rsp_frame_ok);
         end else begin
            want = pending_readings.pop_front();
            check_field("distance", want.distance, rsp_distance);
            check_field("strength", want.strength, rsp_strength);
            check_field("frame_ok", 16'(want.frame_ok), 16'(rsp_frame_ok));
         end
      end
      if (!reset && req_valid && req_ready) parse_rx_byte(req_rx_byte);
   end

   // receiver: random stalls, plus a long hold-off on request
   initial begin
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   // all driving tasks start and end just after a falling edge
   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic send_bytes(input frame_image_type f, input int lo_idx, input int hi_idx);
      for (int k = lo_idx; k <= hi_idx; k++) send_byte(f[k]);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_readings.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic set_header(input logic [7:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= HEADER_ADDR;
      pwdata  <= {24'd0, value};
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      hdr_reg = value;
      @(negedge clock);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      check_field("header_value readback", 16'(hdr_reg), 16'(prdata[7:0]));
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   function automatic frame_image_type make_frame(input logic [7:0] h0, input logic [7:0] h1,
                                                  input logic [15:0] range_word,
                                                  input logic [15:0] str);
      frame_image_type f;
      logic [7:0] sum;
      f[0] = h0;
      f[1] = h1;
      f[2] = range_word[7:0];
      f[3] = range_word[15:8];
      f[4] = str[7:0];
      f[5] = str[15:8];
      f[6] = 8'($urandom_range(0, 255));
      f[7] = 8'($urandom_range(0, 255));
      sum = 8'd0;
      for (int k = 0; k < FRAME_LENGTH - 1; k++) sum += f[k];
      f[FRAME_LENGTH-1] = sum;
      return f;
   endfunction

   function automatic logic [15:0] pick_word();
      case ($urandom_range(0, 7))
         0: return 16'h0000;
         1: return 16'hffff;
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   task automatic test_reset_readback();
      set_header(HEADER_RESET);
   endtask

   task automatic test_idle_noise();
      send_byte(8'h00);
   endtask

   task automatic test_valid_frame();
      send_bytes(make_frame(hdr_reg, hdr_reg, 16'hffff, 16'h0000), 0, FRAME_LENGTH - 1);
   endtask

   task automatic test_second_header_mismatch();
      send_bytes(make_frame(hdr_reg, ~hdr_reg, 16'h1234, 16'hffff), 0, FRAME_LENGTH - 1);
   endtask

   // frame starts under one header and ends under another: must fail
   task automatic test_header_change_mid_frame();
      frame_image_type f;
      f = make_frame(hdr_reg, hdr_reg, 16'h0000, 16'hffff);
      send_bytes(f, 0, 3);
      settle();
      set_header(hdr_reg ^ 8'h01);
      send_bytes(f, 4, FRAME_LENGTH - 1);
   endtask

   // one chunk of traffic; returns the bytes that count as frame content
   task automatic send_random_chunk(output int counted);
      frame_image_type f;
      logic [7:0] h1;
      logic [7:0] b;
      int pick;
      int n;
      pick = $urandom_range(0, 99);
      h1 = (pick >= 80 && pick < 88) ? hdr_reg ^ 8'($urandom_range(1, 255)) : hdr_reg;
      f = make_frame(hdr_reg, h1, pick_word(), pick_word());
      if (pick >= 70 && pick < 80) f[FRAME_LENGTH-1] ^= 8'($urandom_range(1, 255));
      if (pick >= 88 && pick < 94) begin
         n = $urandom_range(1, 4);
         for (int k = 0; k < n; k++) begin
            b = 8'($urandom_range(0, 255));
            if (b == hdr_reg) b = ~b;
            send_byte(b);
         end
         counted = 0;
      end else if (pick >= 94) begin
         // truncated frame: the next header gets swallowed as content
         n = $urandom_range(1, FRAME_LENGTH - 1);
         send_bytes(f, 0, n - 1);
         counted = n;
      end else begin
         send_bytes(f, 0, FRAME_LENGTH - 1);
         counted = FRAME_LENGTH;
      end
   endtask

   task automatic test_random_traffic(input int snd_pct, input int rcv_pct,
                                      input logic [7:0] hdr, input int budget);
      int sent;
      int counted;
      settle();
      set_header(hdr);
      send_idle_pct = snd_pct;
      recv_idle_pct = rcv_pct;
      sent = 0;
      while (sent < budget) begin
         send_random_chunk(counted);
         sent += counted;
      end
   endtask

   // receiver stalls long enough that the parser must stop taking bytes
   task automatic test_result_backpressure();
      settle();
      set_header(HEADER_RESET);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_left = HOLD_CYCLES;
      repeat (6) send_bytes(make_frame(hdr_reg, hdr_reg, pick_word(), pick_word()),
                            0, FRAME_LENGTH - 1);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_idle_pct = 18;
      recv_idle_pct = 48;
      test_reset_readback();
      test_idle_noise();
      test_valid_frame();
      test_second_header_mismatch();
      test_header_change_mid_frame();

      test_random_traffic(18, 48, 8'h00, 250);
      test_random_traffic(48, 18, 8'hff, 250);
      test_random_traffic(0, 0, 8'($urandom_range(0, 255)), 260);
      test_result_backpressure();

      settle();
      if (pending_readings.size() != 0) begin
         $display("%0d expected result items never arrived", pending_readings.size());
         mismatches += pending_readings.size();
      end
      if (mismatches == 0) begin
         $display("lidar_frame_parser regression: pass");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("lidar_frame_parser regression: fail");
      end
      $finish;
   end

endmodule

`default_nettype wire

>>> files.f
rtl/core/lfp_pkg.sv
rtl/core/lfp_cell.sv
rtl/core/lfp_check.sv
rtl/core/lidar_frame_parser.sv
tb/sv/tb_top.sv
